// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the binarize-and-pack unit.
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define RTCBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define RTCBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rtcbp_pkg.sv =====
// ---------------------------------------------------------------------------
// rtcbp_pkg
// Shared types and constants of the two-color binarize and pack unit.
// ---------------------------------------------------------------------------
package rtcbp_pkg;

    // APB register port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Field widths.
    localparam int COLOR_W = 24;
    localparam int WIDTH_W = 9;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;

    // Rows never get wider than this, whatever the build allows.
    localparam int ROW_LIMIT = 256;

    // Squared distance at or below which a pixel counts as transparent.
    localparam int NEAR_LIMIT = 48;
    localparam logic [DIST_W-1:0] NEAR_LIMIT_SQ = DIST_W'(NEAR_LIMIT * NEAR_LIMIT);

    // Bit position of the first pixel of a byte.
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Register reset values.
    localparam logic [COLOR_W-1:0] FORE_COLOR_RST  = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BACK_COLOR_RST  = 24'h000000;
    localparam logic [COLOR_W-1:0] TRANS_COLOR_RST = 24'h000000;
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST   = 9'd8;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_FORE_COLOR   = 3'd0,
        REG_BACK_COLOR   = 3'd1,
        REG_TRANS_COLOR  = 3'd2,
        REG_TRANS_ENABLE = 3'd3,
        REG_INVERT       = 3'd4,
        REG_ROW_WIDTH    = 3'd5
    } cfg_reg_t;

    // Current register contents as seen by the datapath.
    typedef struct packed {
        logic [COLOR_W-1:0] ink_color;
        logic [COLOR_W-1:0] paper_color;
        logic [COLOR_W-1:0] key_color;
        logic               transparency_enable;
        logic               invert_output;
        logic [WIDTH_W-1:0] row_width;
    } cfg_t;

    // One classified pixel on its way to the packer.
    typedef struct packed {
        logic valid;
        logic fg;
    } pix_bit_t;

endpackage

// ===== src/rtcbp_ifs.sv =====
// ---------------------------------------------------------------------------
// rtcbp_ifs
// Valid/ready channels for incoming pixels and outgoing packed bytes.
// ---------------------------------------------------------------------------

// One RGBA pixel per request.
interface rtcbp_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       inside_image;

    modport source (output valid, output red, output green, output blue,
                    output alpha, output inside_image, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha, input inside_image, output ready);
endinterface

// One packed byte per request.
interface rtcbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_bits;
    logic       row_end;

    modport source (output valid, output packed_bits, output row_end, input ready);
    modport sink   (input valid, input packed_bits, input row_end, output ready);
endinterface

// ===== src/rtcbp_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// rtcbp_cfg_regs
// APB register file holding colors, mode bits and the row width.
// ---------------------------------------------------------------------------
module rtcbp_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtcbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rtcbp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rtcbp_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output rtcbp_pkg::cfg_t                  cfg
);
    import rtcbp_pkg::*;

    logic [COLOR_W-1:0] fore_color_reg;
    logic [COLOR_W-1:0] back_color_reg;
    logic [COLOR_W-1:0] trans_color_reg;
    logic               trans_enable_reg;
    logic               invert_reg;
    logic [WIDTH_W-1:0] row_width_reg;
    logic               write_en;
    cfg_reg_t           reg_idx;

    // The access phase of a write updates the register.
    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite && pready;
    assign reg_idx  = cfg_reg_t'(paddr[4:2]);

    // Register writes; unmapped indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_color_reg   <= FORE_COLOR_RST;
            back_color_reg   <= BACK_COLOR_RST;
            trans_color_reg  <= TRANS_COLOR_RST;
            trans_enable_reg <= 1'b0;
            invert_reg       <= 1'b0;
            row_width_reg    <= ROW_WIDTH_RST;
        end
        else if (write_en)
        begin
            case (reg_idx)
                REG_FORE_COLOR:   fore_color_reg   <= pwdata[COLOR_W-1:0];
                REG_BACK_COLOR:   back_color_reg   <= pwdata[COLOR_W-1:0];
                REG_TRANS_COLOR:  trans_color_reg  <= pwdata[COLOR_W-1:0];
                REG_TRANS_ENABLE: trans_enable_reg <= pwdata[0];
                REG_INVERT:       invert_reg       <= pwdata[0];
                REG_ROW_WIDTH:    row_width_reg    <= pwdata[WIDTH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read data follows the address.
    always_comb
    begin
        case (reg_idx)
            REG_FORE_COLOR:   prdata = APB_DATA_W'(fore_color_reg);
            REG_BACK_COLOR:   prdata = APB_DATA_W'(back_color_reg);
            REG_TRANS_COLOR:  prdata = APB_DATA_W'(trans_color_reg);
            REG_TRANS_ENABLE: prdata = APB_DATA_W'(trans_enable_reg);
            REG_INVERT:       prdata = APB_DATA_W'(invert_reg);
            REG_ROW_WIDTH:    prdata = APB_DATA_W'(row_width_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.ink_color           = fore_color_reg;
        cfg.paper_color         = back_color_reg;
        cfg.key_color           = trans_color_reg;
        cfg.transparency_enable = trans_enable_reg;
        cfg.invert_output       = invert_reg;
        cfg.row_width           = row_width_reg;
    end

endmodule

// ===== src/rtcbp_classify.sv =====
// ---------------------------------------------------------------------------
// rtcbp_classify
// Registers each pixel, squares its channel distances to the three reference
// colors, and decides foreground or background.
// ---------------------------------------------------------------------------
module rtcbp_classify (
    input  logic                clk,
    input  logic                rst_n,
    input  rtcbp_pkg::cfg_t     cfg,
    rtcbp_pixel_if.sink         pixel,
    output rtcbp_pkg::pix_bit_t bit_out,
    input  logic                bit_ready
);
    import rtcbp_pkg::*;

    // Squared absolute difference of two channel values.
    function automatic logic [SQ_W-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    // Input register stage.
    logic       a_valid_reg;
    logic [7:0] a_red_reg;
    logic [7:0] a_green_reg;
    logic [7:0] a_blue_reg;
    logic       a_keep_reg;
    logic       a_ready;
    logic       a_keep_next;

    // Squared distances of the registered pixel, one term per channel.
    logic [SQ_W-1:0] fore_sq  [3];
    logic [SQ_W-1:0] back_sq  [3];
    logic [SQ_W-1:0] trans_sq [3];

    logic [DIST_W-1:0] fore_dist;
    logic [DIST_W-1:0] back_dist;
    logic [DIST_W-1:0] trans_dist;
    logic              near_trans;
    logic              closer_fore;

    // The input register loads when it is empty or its pixel moves on.
    assign a_ready     = !a_valid_reg || bit_ready;
    assign pixel.ready = a_ready;

    // Zero alpha or a pixel outside the image is always background.
    assign a_keep_next = pixel.inside_image && (pixel.alpha != 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && pixel.valid)
        begin
            a_red_reg   <= pixel.red;
            a_green_reg <= pixel.green;
            a_blue_reg  <= pixel.blue;
            a_keep_reg  <= a_keep_next;
        end
    end

    // Per-channel squared differences against each reference color.
    always_comb
    begin
        fore_sq[0]  = sq_diff(a_red_reg,   cfg.ink_color[23:16]);
        fore_sq[1]  = sq_diff(a_green_reg, cfg.ink_color[15:8]);
        fore_sq[2]  = sq_diff(a_blue_reg,  cfg.ink_color[7:0]);
        back_sq[0]  = sq_diff(a_red_reg,   cfg.paper_color[23:16]);
        back_sq[1]  = sq_diff(a_green_reg, cfg.paper_color[15:8]);
        back_sq[2]  = sq_diff(a_blue_reg,  cfg.paper_color[7:0]);
        trans_sq[0] = sq_diff(a_red_reg,   cfg.key_color[23:16]);
        trans_sq[1] = sq_diff(a_green_reg, cfg.key_color[15:8]);
        trans_sq[2] = sq_diff(a_blue_reg,  cfg.key_color[7:0]);
    end

    // Sum the channel terms and compare.
    assign fore_dist  = DIST_W'(fore_sq[0]) + DIST_W'(fore_sq[1])
                      + DIST_W'(fore_sq[2]);
    assign back_dist  = DIST_W'(back_sq[0]) + DIST_W'(back_sq[1])
                      + DIST_W'(back_sq[2]);
    assign trans_dist = DIST_W'(trans_sq[0]) + DIST_W'(trans_sq[1])
                      + DIST_W'(trans_sq[2]);

    assign near_trans  = cfg.transparency_enable && (trans_dist <= NEAR_LIMIT_SQ);
    assign closer_fore = (fore_dist <= back_dist) ^ cfg.invert_output;

    // Inversion only applies to pixels that survive the background tests.
    assign bit_out.valid = a_valid_reg;
    assign bit_out.fg    = a_keep_reg && !near_trans && closer_fore;

endmodule

// ===== src/rtcbp_packer.sv =====
// ---------------------------------------------------------------------------
// rtcbp_packer
// Gathers pixel bits MSB first and emits a byte every eight pixels and at
// the end of each row.
// ---------------------------------------------------------------------------
module rtcbp_packer #(
    parameter int MAX_ROW_WIDTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rtcbp_pkg::cfg_t     cfg,
    input  rtcbp_pkg::pix_bit_t bit_in,
    output logic                bit_ready,
    rtcbp_byte_if.source        packed_byte
);
    import rtcbp_pkg::*;

    localparam int ROW_CAP = (MAX_ROW_WIDTH < ROW_LIMIT) ? MAX_ROW_WIDTH : ROW_LIMIT;
    localparam int COL_W   = $clog2(ROW_CAP);
    localparam int CNT_W   = COL_W + 1;

    logic [7:0]       acc_reg;
    logic [7:0]       acc_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             out_valid_reg;
    logic [7:0]       out_bits_reg;
    logic             out_end_reg;

    logic [WIDTH_W-1:0] width_eff;
    logic [CNT_W-1:0]   col_inc;
    logic [7:0]         acc_set;
    logic [7:0]         acc_new;
    logic               end_row;
    logic               emit;
    logic               take;

    // A zero width acts as one; widths past the cap saturate.
    always_comb
    begin
        width_eff = cfg.row_width;
        if (width_eff == '0)
        begin
            width_eff = WIDTH_W'(1);
        end
        if (width_eff > WIDTH_W'(ROW_CAP))
        begin
            width_eff = WIDTH_W'(ROW_CAP);
        end
    end

    // Column advance, row end and byte boundary.
    assign col_inc = CNT_W'(col_reg) + CNT_W'(1);
    assign end_row = WIDTH_W'(col_inc) >= width_eff;
    assign emit    = end_row || (col_inc[2:0] == 3'd0);

    // Place this pixel's bit; the first pixel of a byte lands in bit 7.
    assign acc_set = bit_in.fg ? (8'h01 << (LAST_BIT - col_reg[2:0])) : 8'h00;
    assign acc_new = acc_reg | acc_set;

    // A pixel is taken when the output register can hold a byte.
    assign bit_ready = !out_valid_reg || packed_byte.ready;
    assign take      = bit_in.valid && bit_ready;

    assign acc_next = emit ? 8'h00 : acc_new;
    assign col_next = end_row ? '0 : col_inc[COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            col_reg <= '0;
        end
        else if (take)
        begin
            acc_reg <= acc_next;
            col_reg <= col_next;
        end
    end

    // Output register: loads on an emitted byte, clears once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (packed_byte.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_bits_reg <= acc_new;
            out_end_reg  <= end_row;
        end
    end

    assign packed_byte.valid       = out_valid_reg;
    assign packed_byte.packed_bits = out_bits_reg;
    assign packed_byte.row_end     = out_end_reg;

endmodule

// ===== src/rgba_two_color_binarize_pack_unit.sv =====
// ---------------------------------------------------------------------------
// rgba_two_color_binarize_pack_unit
// Classifies RGBA pixels as foreground or background against two reference
// colors and packs them into 1-bit-per-pixel bytes, one row at a time.
// ---------------------------------------------------------------------------
// Path of a byte: its last pixel is accepted into the input register, then classified
// and packed into the output register, unless a stalled output byte holds it back.
// Throughput: one pixel per clock; both register stages reload in the cycle they
// hand on, so only a stalled output byte holds the input back.
// Reset clears the bit accumulator, the column counter and all valid flags,
// and loads the register defaults; no clearing pass is needed.
module rgba_two_color_binarize_pack_unit #(
    parameter int MAX_ROW_WIDTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtcbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rtcbp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rtcbp_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    rtcbp_pixel_if.sink                      pixel,
    rtcbp_byte_if.source                     packed_byte
);
    import rtcbp_pkg::*;

    cfg_t     cfg;
    pix_bit_t pix_bit;
    logic     pix_bit_ready;

    // Register file.
    rtcbp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pixel input register and classification.
    rtcbp_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pixel     (pixel),
        .bit_out   (pix_bit),
        .bit_ready (pix_bit_ready)
    );

    // Bit packing and output register.
    rtcbp_packer #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .bit_in      (pix_bit),
        .bit_ready   (pix_bit_ready),
        .packed_byte (packed_byte)
    );

endmodule

// ===== src/rtcbp_checker.sv =====
// ---------------------------------------------------------------------------
// rtcbp_port_checker
// Port-level checks of the binarize-and-pack unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcbp_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_bits,
    input logic       out_end
);

    logic       stalled;
    logic [8:0] out_word;

    assign stalled  = out_valid && !out_ready;
    assign out_word = {out_bits, out_end};

    // A stalled byte stays offered.
    `RTCBP_ASSERT_NEXT(a_out_hold, stalled, out_valid, "output request dropped")

    // A stalled byte keeps its contents.
    `RTCBP_ASSERT_NEXT(a_out_stable, stalled, $stable(out_word), "stalled output changed")

    // With the output side free, the pipeline always takes a pixel.
    `RTCBP_ASSERT_SAME(a_in_ready, !out_valid || out_ready, in_ready, "input blocked")

    // No byte is offered right out of reset.
    `RTCBP_ASSERT_SAME(a_reset_clean, $rose(rst_n), !out_valid, "output request after reset")

endmodule

bind rgba_two_color_binarize_pack_unit rtcbp_port_checker u_rtcbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pixel.ready),
    .out_valid (packed_byte.valid),
    .out_ready (packed_byte.ready),
    .out_bits  (packed_byte.packed_bits),
    .out_end   (packed_byte.row_end)
);

// ===== sim/rtcbp_checker.sv =====
// ---------------------------------------------------------------------------
// rtcbp_checker
// Watches the register port and both request channels of the binarize and
// pack unit, predicts every packed byte from the accepted pixels and compares
// each delivered byte field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module rtcbp_checker #(
    parameter int MAX_ROW_WIDTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [rtcbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rtcbp_pkg::APB_DATA_W-1:0] pwdata,
    rtcbp_pixel_if                           pixel,
    rtcbp_byte_if                            packed_byte,
    output int                               pending_bytes,
    output int                               failures
);
    import rtcbp_pkg::*;

    typedef struct packed {
        logic [7:0] packed_bits;
        logic       row_end;
    } byte_result_t;

    // Local copy of the registers and of the packing state.
    cfg_t         shadow_cfg;
    logic [7:0]   gathered_bits;
    logic [7:0]   column;
    byte_result_t awaited_bytes[$];
    int           errors;

    // Squared RGB distance from a pixel to a packed reference color.
    function automatic int dist_to(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [COLOR_W-1:0] c);
        int dr;
        int dg;
        int db;
        dr = int'(r) - int'(c[23:16]);
        dg = int'(g) - int'(c[15:8]);
        db = int'(b) - int'(c[7:0]);
        return dr * dr + dg * dg + db * db;
    endfunction

    // Foreground decision for one pixel under the current registers.
    function automatic logic is_ink(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic [7:0] a,
                                    input logic in_image);
        logic ink;
        if (!in_image || a == 8'd0)
            return 1'b0;
        if (shadow_cfg.transparency_enable &&
            dist_to(r, g, b, shadow_cfg.key_color) <= NEAR_LIMIT * NEAR_LIMIT)
            return 1'b0;
        ink = dist_to(r, g, b, shadow_cfg.ink_color) <= dist_to(r, g, b, shadow_cfg.paper_color);
        return ink ^ shadow_cfg.invert_output;
    endfunction

    // Row width as the datapath uses it: zero becomes one, large values saturate.
    function automatic int row_span();
        int w;
        int cap;
        cap = (MAX_ROW_WIDTH < ROW_LIMIT) ? MAX_ROW_WIDTH : ROW_LIMIT;
        w = int'(shadow_cfg.row_width);
        if (w == 0)
            w = 1;
        if (w > cap)
            w = cap;
        return w;
    endfunction

    // Adds one pixel bit to the current byte and queues the byte when it closes.
    task automatic pack_pixel(input logic ink);
        int           next;
        logic         row_done;
        byte_result_t result;
        next = int'(column) + 1;
        row_done = next >= row_span();
        if (ink)
            gathered_bits = gathered_bits | (8'h80 >> column[2:0]);
        if (row_done || (next % 8) == 0) begin
            result.packed_bits = gathered_bits;
            result.row_end = row_done;
            awaited_bytes = {awaited_bytes, result};
            gathered_bits = 8'h00;
            column = row_done ? 8'd0 : next[7:0];
        end
        else begin
            column = next[7:0];
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        byte_result_t want;
        if (!rst_n) begin
            shadow_cfg = '{ink_color: FORE_COLOR_RST, paper_color: BACK_COLOR_RST,
                           key_color: TRANS_COLOR_RST, transparency_enable: 1'b0,
                           invert_output: 1'b0, row_width: ROW_WIDTH_RST};
            gathered_bits = 8'h00;
            column = 8'd0;
            awaited_bytes.delete();
            errors = 0;
            pending_bytes <= 0;
            failures <= 0;
        end
        else begin
            // Delivered bytes are matched first; a byte never stems from a
            // pixel accepted at the same edge.
            if (packed_byte.valid && packed_byte.ready) begin
                if (awaited_bytes.size() == 0) begin
                    $error("unexpected byte: packed_bits %02h row_end %0b",
                           packed_byte.packed_bits, packed_byte.row_end);
                    errors++;
                end
                else begin
                    want = awaited_bytes.pop_front();
                    if (packed_byte.packed_bits !== want.packed_bits) begin
                        $error("packed_bits mismatch: expected %02h, actual %02h",
                               want.packed_bits, packed_byte.packed_bits);
                        errors++;
                    end
                    if (packed_byte.row_end !== want.row_end) begin
                        $error("row_end mismatch: expected %0b, actual %0b",
                               want.row_end, packed_byte.row_end);
                        errors++;
                    end
                end
            end

            // Register writes complete in the access cycle.
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[APB_ADDR_W-1:2]))
                    REG_FORE_COLOR:   shadow_cfg.ink_color = pwdata[COLOR_W-1:0];
                    REG_BACK_COLOR:   shadow_cfg.paper_color = pwdata[COLOR_W-1:0];
                    REG_TRANS_COLOR:  shadow_cfg.key_color = pwdata[COLOR_W-1:0];
                    REG_TRANS_ENABLE: shadow_cfg.transparency_enable = pwdata[0];
                    REG_INVERT:       shadow_cfg.invert_output = pwdata[0];
                    REG_ROW_WIDTH:    shadow_cfg.row_width = pwdata[WIDTH_W-1:0];
                    default: ;
                endcase
            end

            // Accepted pixels go through the predictor.
            if (pixel.valid && pixel.ready)
                pack_pixel(is_ink(pixel.red, pixel.green, pixel.blue, pixel.alpha,
                                  pixel.inside_image));

            pending_bytes <= awaited_bytes.size();
            failures <= errors;
        end
    end

endmodule

// ===== sim/rgba_two_color_binarize_pack_unit_tb.sv =====
// ---------------------------------------------------------------------------
// rgba_two_color_binarize_pack_unit_tb
// Drives pixels and register writes into the binarize and pack unit with
// random gaps and output stalls: a short directed part for the corner cases,
// then random register settings and pixel rows. The checker beside the unit
// predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module rgba_two_color_binarize_pack_unit_tb;
    import rtcbp_pkg::*;

    localparam int MAX_ROW_WIDTH = 256;
    localparam int RANDOM_PIXELS = 600;
    localparam int CALM_AFTER    = 500;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rtcbp_pixel_if pixel ();
    rtcbp_byte_if  packed_byte ();

    int   pending_bytes;
    int   failures;
    int   cycle_count = 0;
    int   stall_left = 0;
    int   gap_pct;
    int   stall_pct;
    bit   calm;
    int   random_sent;

    // Colors of the current setting, used to aim pixels near them.
    logic [COLOR_W-1:0] fore_pick;
    logic [COLOR_W-1:0] back_pick;
    logic [COLOR_W-1:0] trans_pick;

    rgba_two_color_binarize_pack_unit #(
        .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pixel      (pixel),
        .packed_byte(packed_byte)
    );

    rtcbp_checker #(
        .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pixel        (pixel),
        .packed_byte  (packed_byte),
        .pending_bytes(pending_bytes),
        .failures     (failures)
    );

    // Clock generation.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: ready, with random stall bursts of random length.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
        else if (!calm && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            packed_byte.ready <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end
        else begin
            packed_byte.ready <= 1'b1;
        end
    end

    // Register write: setup phase, then access phase until pready, then the bus goes idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one pixel, after an occasional random gap, and waits until it is taken.
    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a, input logic in_image);
        if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            pixel.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        pixel.valid <= 1'b1;
        pixel.red <= r;
        pixel.green <= g;
        pixel.blue <= b;
        pixel.alpha <= a;
        pixel.inside_image <= in_image;
        do @(posedge clk); while (!pixel.ready);
    endtask

    // Waits until every predicted byte has arrived and the pipeline is empty.
    task automatic settle();
        pixel.valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] jitter(input logic [7:0] base, input int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 3))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return COLOR_W'($urandom());
        endcase
    endfunction

    function automatic int span_of(input logic [WIDTH_W-1:0] w);
        if (w == 0)
            return 1;
        if (int'(w) > ROW_LIMIT)
            return ROW_LIMIT;
        return int'(w);
    endfunction

    // One random pixel, often aimed close to one of the reference colors.
    task automatic random_pixel();
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [7:0]         a;
        logic               in_image;
        logic [COLOR_W-1:0] base;
        bit                 aimed;
        r = 8'($urandom());
        g = 8'($urandom());
        b = 8'($urandom());
        a = 8'($urandom_range(1, 255));
        in_image = 1'b1;
        aimed = 1'b0;
        case ($urandom_range(0, 11))
            0: a = 8'h00;
            1: in_image = 1'b0;
            2, 3: begin
                base = trans_pick;
                aimed = 1'b1;
            end
            4: begin
                base = fore_pick;
                aimed = 1'b1;
            end
            5: begin
                base = back_pick;
                aimed = 1'b1;
            end
            6: begin
                r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                a = $urandom_range(0, 1) ? 8'hFF : 8'h01;
            end
            7: a = 8'hFF;
            default: ;
        endcase
        if (aimed) begin
            r = jitter(base[23:16], 40);
            g = jitter(base[15:8], 40);
            b = jitter(base[7:0], 40);
        end
        push_pixel(r, g, b, a, in_image);
    endtask

    initial begin
        int               phase;
        int               span;
        int               count;
        logic [WIDTH_W-1:0] width_pick;

        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pixel.valid = 1'b0;
        pixel.red = 8'h00;
        pixel.green = 8'h00;
        pixel.blue = 8'h00;
        pixel.alpha = 8'h00;
        pixel.inside_image = 1'b0;
        packed_byte.ready = 1'b0;
        calm = 1'b0;
        gap_pct = 20;
        stall_pct = 20;
        random_sent = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: white ink on black paper, eight pixels per row.
        push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd200, 8'd200, 8'd200, 8'd1, 1'b1);
        push_pixel(8'd127, 8'd127, 8'd127, 8'd255, 1'b1);
        push_pixel(8'd128, 8'd128, 8'd128, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd0, 8'd255, 8'd128, 1'b1);
        settle();

        // Transparency right at the distance limit and just past it, with
        // inversion, which must not touch forced background.
        write_reg(REG_TRANS_COLOR, 32'h00808080);
        write_reg(REG_TRANS_ENABLE, 32'd1);
        write_reg(REG_INVERT, 32'd1);
        push_pixel(8'd176, 8'd128, 8'd128, 8'd255, 1'b1);
        push_pixel(8'd177, 8'd128, 8'd128, 8'd255, 1'b1);
        push_pixel(8'd128, 8'd80, 8'd128, 8'd255, 1'b1);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        settle();

        // Shrinking the width below the current column closes the row at once.
        write_reg(REG_ROW_WIDTH, 32'd3);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        settle();

        // Equal reference colors tie every distance; width zero acts as one.
        write_reg(REG_FORE_COLOR, 32'h00404040);
        write_reg(REG_BACK_COLOR, 32'h00404040);
        write_reg(REG_TRANS_ENABLE, 32'd0);
        write_reg(REG_INVERT, 32'd0);
        write_reg(REG_ROW_WIDTH, 32'd0);
        push_pixel(8'd10, 8'd200, 8'd30, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        settle();

        // Random settings, each followed by a batch of rows.
        phase = 0;
        while (random_sent < RANDOM_PIXELS) begin
            fore_pick = pick_color();
            back_pick = $urandom_range(0, 9) == 0 ? fore_pick : pick_color();
            trans_pick = pick_color();
            if (phase == 0)
                width_pick = 9'd256;
            else if (phase == 1)
                width_pick = 9'h1FF;
            else begin
                case ($urandom_range(0, 19))
                    0: width_pick = 9'd0;
                    1: width_pick = 9'd256;
                    2: width_pick = 9'($urandom_range(257, 511));
                    3: width_pick = 9'd255;
                    4, 5: width_pick = 9'd8;
                    6: width_pick = 9'd16;
                    default: width_pick = 9'($urandom_range(1, 24));
                endcase
            end
            write_reg(REG_FORE_COLOR, {8'h00, fore_pick});
            write_reg(REG_BACK_COLOR, {8'h00, back_pick});
            write_reg(REG_TRANS_COLOR, {8'h00, trans_pick});
            write_reg(REG_TRANS_ENABLE, 32'($urandom_range(0, 1)));
            write_reg(REG_INVERT, 32'($urandom_range(0, 1)));
            write_reg(REG_ROW_WIDTH, {23'd0, width_pick});

            if (!calm) begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 5;
                    2: gap_pct = 25;
                    default: gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    2: stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end

            // Mostly whole rows; sometimes a row is left open for the next setting.
            span = span_of(width_pick);
            count = span * $urandom_range(1, (span >= 48) ? 1 : 48 / span);
            if (span > 1 && $urandom_range(0, 3) == 0)
                count = count + $urandom_range(1, span - 1);
            if (count > RANDOM_PIXELS - random_sent)
                count = RANDOM_PIXELS - random_sent;

            repeat (count) begin
                random_pixel();
                random_sent++;
                if (random_sent == CALM_AFTER)
                    calm = 1'b1;
            end
            settle();
            phase++;
        end

        // Drain and give the verdict.
        settle();
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
